// ===== hw/rtl/static_linked_list_engine_unit_assert.svh =====
// Assertion helpers for the linked list engine.
// Both sample on clk and are disabled while rst_n is low.
`ifndef STATIC_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sllu_pkg.sv =====
`default_nettype none

package sllu_pkg;

  // Default sizing of the node store
  localparam int SLLU_DEPTH      = 1024;
  localparam int SLLU_DATA_WIDTH = 32;

  // Fixed field widths of the command and result transfers
  localparam int CMD_W  = 2;
  localparam int HEAD_W = 10;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_ALLOC  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOFREE   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [HEAD_W-1:0]        head;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [HEAD_W-1:0]        index;
    logic signed [VAL_W-1:0]  removed;
  } out_item_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic busy;      // not in idle
    logic done;      // result produced this cycle
    logic clearing;  // post-reset link sweep running
  } core_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sllu_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read.
module sllu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sllu_core.sv =====
`default_nettype none

// Sequencer and datapath: walks the next-index store one node per cycle
// and performs the link updates one write per cycle.
module sllu_core
  import sllu_pkg::*;
#(
  parameter int DEPTH      = SLLU_DEPTH,
  parameter int DATA_WIDTH = SLLU_DATA_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire in_item_t   in_item,
  output core_stat_t      stat,
  output out_item_t       res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_INIT  = 13'h0002,
    S_WALK  = 13'h0004,
    S_LOC0  = 13'h0008,
    S_LOC   = 13'h0010,
    S_FREE1 = 13'h0020,
    S_FREE2 = 13'h0040,
    S_LINKQ = 13'h0080,
    S_LINKP = 13'h0100,
    S_DEL1  = 13'h0200,
    S_DEL2  = 13'h0400,
    S_DEL3  = 13'h0800,
    S_SPARE = 13'h1000
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [IDX_W-1:0]       p_r, p_nxt;
  logic [IDX_W-1:0]       q_r, q_nxt;
  logic [IDX_W-1:0]       succ_r, succ_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]       rem_r, rem_nxt;

  // memory ports
  logic [IDX_W-1:0]       raddr;
  logic                   nx_we;
  logic [IDX_W-1:0]       nx_waddr;
  logic [IDX_W-1:0]       nx_wdata;
  logic [IDX_W-1:0]       nx_rdata;
  logic                   dt_we;
  logic [DATA_WIDTH-1:0]  dt_rdata;

  // input decode
  logic [31:0]            hd32;
  logic                   hd_ok;
  logic [IDX_W-1:0]       hd_i;
  logic [63:0]            val64;
  logic [63:0]            dt64;
  logic                   done;

  assign hd32  = 32'(in_item.head);
  assign hd_ok = (hd32 != 32'd0) && (hd32 < 32'(DEPTH));
  assign hd_i  = hd32[IDX_W-1:0];
  assign val64 = {{32{in_item.value[VAL_W-1]}}, in_item.value};
  assign dt64  = 64'(dt_rdata);

  // Next-index store and data store share one read address
  sllu_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (raddr),
    .rdata (nx_rdata)
  );

  sllu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (q_r),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (dt_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    succ_nxt  = succ_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    raddr     = '0;
    nx_we     = 1'b0;
    nx_waddr  = p_r;
    nx_wdata  = '0;
    dt_we     = 1'b0;
    done      = 1'b0;
    res       = '{status: ST_OK, index: '0, removed: '0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_item.command);
          pos_nxt = in_item.position;
          val_nxt = val64[DATA_WIDTH-1:0];
          cnt_nxt = CNT_W'(1);
          p_nxt   = hd_i;
          unique case (cmd_t'(in_item.command))
            CMD_INSERT, CMD_DELETE: begin
              if ((in_item.position == '0) || !hd_ok) begin
                done       = 1'b1;
                res.status = ST_BADPOS;
              end else begin
                raddr     = hd_i;
                state_nxt = S_WALK;
              end
            end
            CMD_LOCATE: begin
              if (!hd_ok) begin
                done       = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                raddr     = hd_i;
                state_nxt = S_LOC0;
              end
            end
            CMD_ALLOC: begin
              succ_nxt  = '0;
              state_nxt = S_FREE1;
            end
          endcase
        end
      end

      // link sweep after reset: entry k points at k+1, last at 0
      S_INIT: begin
        nx_we    = 1'b1;
        nx_waddr = clr_r;
        nx_wdata = (clr_r == IDX_W'(DEPTH - 1)) ? '0 : clr_r + IDX_W'(1);
        clr_nxt  = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // nx_rdata holds the successor of p_r
      S_WALK: begin
        if (cnt_r < CNT_W'(pos_r)) begin
          if (nx_rdata == '0) begin
            done       = 1'b1;
            res.status = ST_BADPOS;
            state_nxt  = S_IDLE;
          end else begin
            p_nxt   = nx_rdata;
            cnt_nxt = cnt_r + CNT_W'(1);
            raddr   = nx_rdata;
          end
        end else if (cmd_r == CMD_INSERT) begin
          succ_nxt  = nx_rdata;
          state_nxt = S_FREE1;
        end else if (nx_rdata == '0) begin
          done       = 1'b1;
          res.status = ST_BADPOS;
          state_nxt  = S_IDLE;
        end else begin
          q_nxt     = nx_rdata;
          raddr     = nx_rdata;
          state_nxt = S_DEL1;
        end
      end

      // first node after the header
      S_LOC0: begin
        if (nx_rdata == '0) begin
          done       = 1'b1;
          res.status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          p_nxt     = nx_rdata;
          raddr     = nx_rdata;
          cnt_nxt   = '0;
          state_nxt = S_LOC;
        end
      end

      // compare one node per cycle, bounded by DEPTH compares
      S_LOC: begin
        if (dt_rdata == val_r) begin
          done      = 1'b1;
          res.index = HEAD_W'(p_r);
          state_nxt = S_IDLE;
        end else if ((nx_rdata == '0) || (cnt_r == CNT_W'(DEPTH - 1))) begin
          done       = 1'b1;
          res.status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          p_nxt   = nx_rdata;
          raddr   = nx_rdata;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // nx_rdata is the free-list head
      S_FREE1: begin
        if (nx_rdata == '0) begin
          done       = 1'b1;
          res.status = ST_NOFREE;
          state_nxt  = S_IDLE;
        end else begin
          q_nxt     = nx_rdata;
          raddr     = nx_rdata;
          state_nxt = S_FREE2;
        end
      end

      // pop: free head moves to the successor of q
      S_FREE2: begin
        nx_we     = 1'b1;
        nx_waddr  = '0;
        nx_wdata  = nx_rdata;
        dt_we     = (cmd_r == CMD_INSERT);
        state_nxt = S_LINKQ;
      end

      S_LINKQ: begin
        nx_we    = 1'b1;
        nx_waddr = q_r;
        nx_wdata = succ_r;
        if (cmd_r == CMD_ALLOC) begin
          done      = 1'b1;
          res.index = HEAD_W'(q_r);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LINKP;
        end
      end

      S_LINKP: begin
        nx_we     = 1'b1;
        nx_waddr  = p_r;
        nx_wdata  = q_r;
        done      = 1'b1;
        state_nxt = S_IDLE;
      end

      // unlink q; fetch the free head for the push
      S_DEL1: begin
        rem_nxt   = dt64[VAL_W-1:0];
        nx_we     = 1'b1;
        nx_waddr  = p_r;
        nx_wdata  = nx_rdata;
        raddr     = '0;
        state_nxt = S_DEL2;
      end

      S_DEL2: begin
        nx_we     = 1'b1;
        nx_waddr  = q_r;
        nx_wdata  = nx_rdata;
        state_nxt = S_DEL3;
      end

      S_DEL3: begin
        nx_we       = 1'b1;
        nx_waddr    = '0;
        nx_wdata    = q_r;
        done        = 1'b1;
        res.removed = rem_r;
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    succ_r <= succ_nxt;
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
  end

  assign stat.busy     = (state_r != S_IDLE);
  assign stat.done     = done;
  assign stat.clearing = (state_r == S_INIT);

endmodule

`default_nettype wire

// ===== hw/rtl/static_linked_list_engine_unit.sv =====
// Channel   Ports                 Transfer
// command   start, in_item        start high while busy is low
// result    out_valid, out_item   out_valid high for one cycle, always taken
//
// After reset the block sweeps all DEPTH entries of the next-index store,
// one entry per cycle, with busy high, before the first command is taken.
// A rejected command is answered without busy going high. The walk reads
// one node per cycle from the next-index RAM; link updates share its
// single write port. The result is registered and appears in the cycle
// after the last busy cycle. Reset is synchronous, active low.
// The receiver cannot stall the result.
`default_nettype none

`include "static_linked_list_engine_unit_assert.svh"

module static_linked_list_engine_unit
  import sllu_pkg::*;
#(
  parameter int DEPTH      = SLLU_DEPTH,
  parameter int DATA_WIDTH = SLLU_DATA_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  core_stat_t stat;
  out_item_t  res;
  logic       out_valid_r;
  out_item_t  out_item_r;

  sllu_core #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .stat    (stat),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.done;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_item_r <= res;
    end
  end

  assign busy      = stat.busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `SLLU_ASSERT_NOW(a_done_needs_cmd, stat.done, stat.busy || start, "result without a command")
  `SLLU_ASSERT_NOW(a_sweep_busy, stat.clearing, stat.busy && !stat.done, "activity during sweep")
  `SLLU_ASSERT_NEXT(a_done_to_idle, stat.done && stat.busy, !stat.busy, "no return to idle")
  `SLLU_ASSERT_NOW(a_fail_zero, out_valid && (out_item.status != ST_OK), (out_item.index == '0) && (out_item.removed == '0), "failed result carries data")

endmodule

`default_nettype wire
